// ===== rtl/xpath_expression_lexer_top_defines.svh =====
// Assertion macros for the expression lexer.
// Simulation builds get the checks; SYNTH builds get empty bodies.
`ifndef XPATH_EXPRESSION_LEXER_TOP_DEFINES_SVH
`define XPATH_EXPRESSION_LEXER_TOP_DEFINES_SVH

`ifndef SYNTH
`define XEL_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("xel: invariant violated");
`define XEL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("xel: implication violated");
`else
`define XEL_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define XEL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/xel_pkg.sv =====
`timescale 1ns / 1ps

package xel_pkg;

	localparam int DEF_MAX_SOURCE_BYTES = 65536;

	localparam logic [5:0] K_AND    = 6'd0;
	localparam logic [5:0] K_OR     = 6'd1;
	localparam logic [5:0] K_DIV    = 6'd2;
	localparam logic [5:0] K_IDIV   = 6'd3;
	localparam logic [5:0] K_MOD    = 6'd4;
	localparam logic [5:0] K_NAME   = 6'd5;
	localparam logic [5:0] K_STRING = 6'd6;
	localparam logic [5:0] K_NUMBER = 6'd7;
	localparam logic [5:0] K_STAR   = 6'd8;
	localparam logic [5:0] K_DSLASH = 6'd9;
	localparam logic [5:0] K_DDOT   = 6'd10;
	localparam logic [5:0] K_NE     = 6'd11;
	localparam logic [5:0] K_LE     = 6'd12;
	localparam logic [5:0] K_GE     = 6'd13;
	localparam logic [5:0] K_ASSIGN = 6'd14;
	localparam logic [5:0] K_SLASH  = 6'd15;
	localparam logic [5:0] K_DOT    = 6'd16;
	localparam logic [5:0] K_AT     = 6'd17;
	localparam logic [5:0] K_QUEST  = 6'd18;
	localparam logic [5:0] K_LPAREN = 6'd19;
	localparam logic [5:0] K_RPAREN = 6'd20;
	localparam logic [5:0] K_LBRACK = 6'd21;
	localparam logic [5:0] K_RBRACK = 6'd22;
	localparam logic [5:0] K_LBRACE = 6'd23;
	localparam logic [5:0] K_RBRACE = 6'd24;
	localparam logic [5:0] K_COMMA  = 6'd25;
	localparam logic [5:0] K_COLON  = 6'd26;
	localparam logic [5:0] K_PLUS   = 6'd27;
	localparam logic [5:0] K_MINUS  = 6'd28;
	localparam logic [5:0] K_EQ     = 6'd29;
	localparam logic [5:0] K_LT     = 6'd30;
	localparam logic [5:0] K_GT     = 6'd31;
	localparam logic [5:0] K_PIPE   = 6'd32;
	localparam logic [5:0] K_END    = 6'd33;
	localparam logic [5:0] K_NONE   = 6'd63;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_COMMENT  = 3'd1;
	localparam logic [2:0] ERR_STRING   = 3'd2;
	localparam logic [2:0] ERR_BAD_CHAR = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG = 3'd4;

	// Keywords packed little-endian, first byte in the low octet.
	localparam logic [31:0] KW_OR   = 32'h0000_726f;
	localparam logic [31:0] KW_AND  = 32'h0064_6e61;
	localparam logic [31:0] KW_DIV  = 32'h0076_6964;
	localparam logic [31:0] KW_MOD  = 32'h0064_6f6d;
	localparam logic [31:0] KW_IDIV = 32'h7669_6469;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_NAME,
		PH_NUMBER,
		PH_STRING,
		PH_COMMENT,
		PH_OPCHAR,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [2:0]  err;
	} res_t;

	// All results caused by one request.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} bundle_t;

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"/":     k = K_SLASH;
			".":     k = K_DOT;
			"@":     k = K_AT;
			"?":     k = K_QUEST;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"[":     k = K_LBRACK;
			"]":     k = K_RBRACK;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			",":     k = K_COMMA;
			":":     k = K_COLON;
			"+":     k = K_PLUS;
			"-":     k = K_MINUS;
			"=":     k = K_EQ;
			"<":     k = K_LT;
			">":     k = K_GT;
			"|":     k = K_PIPE;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/xel_core.sv =====
`timescale 1ns / 1ps

module xel_core #(
	parameter int MAX_SOURCE_BYTES = xel_pkg::DEF_MAX_SOURCE_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       source_byte,
	input  logic             end_of_source,
	output xel_pkg::bundle_t bundle
);
	import xel_pkg::*;

	localparam int POS_W = $clog2(MAX_SOURCE_BYTES + 1);
	localparam int CW    = POS_W + 16;

	phase_t            ph_q, ph_d;
	logic [7:0]        pc_q, pc_d;
	logic [7:0]        qc_q, qc_d;
	logic              qs_q, qs_d;
	logic              col_q, col_d;
	logic [POS_W-1:0]  ts_q, ts_d;
	logic [POS_W-1:0]  bp_q, bp_d;
	logic [31:0]       kb_q, kb_d;

	phase_t            st_ph;
	logic              st_space;
	logic              st_emit;
	res_t              st_res;
	logic [5:0]        st_sk;

	logic [POS_W-1:0]  len;
	logic [7:0]        c;

	function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
		if (CW'(v) > CW'(16'hffff)) begin
			return 16'hffff;
		end
		return 16'(v);
	endfunction

	function automatic res_t mk(input logic [5:0] k, input logic [POS_W-1:0] off,
			input logic [POS_W-1:0] ln, input logic [2:0] e);
		res_t r;
		r.kind   = k;
		r.offset = sat16(off);
		r.length = sat16(ln);
		r.err    = e;
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == " ") || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic [5:0] name_kind(input logic [POS_W-1:0] ln,
			input logic [31:0] kb);
		logic [5:0] k;
		k = K_NAME;
		if (ln == POS_W'(2) && kb == KW_OR) begin
			k = K_OR;
		end else if (ln == POS_W'(3) && kb == KW_AND) begin
			k = K_AND;
		end else if (ln == POS_W'(3) && kb == KW_DIV) begin
			k = K_DIV;
		end else if (ln == POS_W'(3) && kb == KW_MOD) begin
			k = K_MOD;
		end else if (ln == POS_W'(4) && kb == KW_IDIV) begin
			k = K_IDIV;
		end
		return k;
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] b);
		logic [5:0] k;
		k = K_NONE;
		if (p == "/" && b == "/") begin
			k = K_DSLASH;
		end else if (p == "." && b == ".") begin
			k = K_DDOT;
		end else if (p == "!" && b == "=") begin
			k = K_NE;
		end else if (p == "<" && b == "=") begin
			k = K_LE;
		end else if (p == ">" && b == "=") begin
			k = K_GE;
		end else if (p == ":" && b == "=") begin
			k = K_ASSIGN;
		end
		return k;
	endfunction

	assign c   = source_byte;
	assign len = bp_q - ts_q;

	// What the byte does when it opens a new token.
	always_comb begin
		st_space = is_space(c);
		st_sk    = single_kind(c);
		st_emit  = 1'b0;
		st_res   = mk(K_END, bp_q, '0, ERR_NONE);
		st_ph    = PH_IDLE;
		if (st_space) begin
			st_ph = PH_IDLE;
		end else if (c == "(" || c == "/" || c == "." || c == "!" || c == "<" ||
				c == ">" || c == ":") begin
			st_ph = PH_OPCHAR;
		end else if (c == "'" || c == "\"") begin
			st_ph = PH_STRING;
		end else if (is_digit(c)) begin
			st_ph = PH_NUMBER;
		end else if (is_alpha(c) || c == "_") begin
			st_ph = PH_NAME;
		end else if (c == "*") begin
			st_emit = 1'b1;
			st_res  = mk(K_STAR, bp_q, POS_W'(1), ERR_NONE);
		end else if (st_sk != K_NONE) begin
			st_emit = 1'b1;
			st_res  = mk(st_sk, bp_q, POS_W'(1), ERR_NONE);
		end else begin
			st_emit = 1'b1;
			st_ph   = PH_ERROR;
			st_res  = mk(K_END, bp_q, '0, ERR_BAD_CHAR);
		end
	end

	always_comb begin
		logic       do_start;
		logic       tok_v;
		res_t       tok;
		logic       sec_v;
		res_t       sec;
		logic [5:0] pk;

		ph_d     = ph_q;
		pc_d     = pc_q;
		qc_d     = qc_q;
		qs_d     = qs_q;
		col_d    = col_q;
		ts_d     = ts_q;
		bp_d     = bp_q;
		kb_d     = kb_q;
		do_start = 1'b0;
		tok_v    = 1'b0;
		tok      = mk(K_END, bp_q, '0, ERR_NONE);
		sec_v    = 1'b0;
		sec      = mk(K_END, bp_q, '0, ERR_NONE);
		pk       = pair_kind(pc_q, c);

		if (end_of_source) begin
			// Flush the pending token, then the end token unless an error closes it.
			sec_v = (ph_q != PH_ERROR);
			case (ph_q)
				PH_NAME: begin
					tok_v = 1'b1;
					tok   = mk(name_kind(len, kb_q), ts_q, len, ERR_NONE);
				end
				PH_NUMBER: begin
					tok_v = 1'b1;
					tok   = mk(K_NUMBER, ts_q, len, ERR_NONE);
				end
				PH_STRING: begin
					tok_v = 1'b1;
					if (qs_q) begin
						tok = mk(K_STRING, ts_q, len, ERR_NONE);
					end else begin
						tok   = mk(K_END, ts_q, '0, ERR_STRING);
						sec_v = 1'b0;
					end
				end
				PH_COMMENT: begin
					tok_v = 1'b1;
					tok   = mk(K_END, ts_q, '0, ERR_COMMENT);
					sec_v = 1'b0;
				end
				PH_OPCHAR: begin
					tok_v = 1'b1;
					if (pc_q == "!") begin
						tok   = mk(K_END, ts_q, '0, ERR_BAD_CHAR);
						sec_v = 1'b0;
					end else begin
						tok = mk(single_kind(pc_q), ts_q, POS_W'(1), ERR_NONE);
					end
				end
				default: begin
				end
			endcase
			ph_d  = PH_IDLE;
			pc_d  = '0;
			qc_d  = '0;
			qs_d  = 1'b0;
			col_d = 1'b0;
			ts_d  = '0;
			bp_d  = '0;
			kb_d  = '0;
		end else if (ph_q != PH_ERROR) begin
			if (bp_q >= POS_W'(MAX_SOURCE_BYTES)) begin
				tok_v = 1'b1;
				tok   = mk(K_END, bp_q, '0, ERR_TOO_LONG);
				ph_d  = PH_ERROR;
			end else begin
				bp_d = bp_q + POS_W'(1);
				case (ph_q)
					PH_NAME: begin
						if (is_alpha(c) || is_digit(c) || c == "_" || c == "-" ||
								c == "." || c == ":") begin
							if (len < POS_W'(4)) begin
								kb_d = kb_q | (32'(c) << {len[1:0], 3'b000});
							end
						end else begin
							tok_v    = 1'b1;
							tok      = mk(name_kind(len, kb_q), ts_q, len, ERR_NONE);
							do_start = 1'b1;
						end
					end
					PH_NUMBER: begin
						if (!(is_digit(c) || c == "." || c == "e" || c == "E" ||
								c == "+" || c == "-")) begin
							tok_v    = 1'b1;
							tok      = mk(K_NUMBER, ts_q, len, ERR_NONE);
							do_start = 1'b1;
						end
					end
					PH_STRING: begin
						if (qs_q) begin
							if (c == qc_q) begin
								qs_d = 1'b0;
							end else begin
								tok_v    = 1'b1;
								tok      = mk(K_STRING, ts_q, len, ERR_NONE);
								do_start = 1'b1;
							end
						end else if (c == qc_q) begin
							qs_d = 1'b1;
						end
					end
					PH_COMMENT: begin
						if (col_q && c == ")") begin
							ph_d  = PH_IDLE;
							col_d = 1'b0;
						end else begin
							col_d = (c == ":");
						end
					end
					PH_OPCHAR: begin
						if (pk != K_NONE) begin
							tok_v = 1'b1;
							tok   = mk(pk, ts_q, POS_W'(2), ERR_NONE);
							ph_d  = PH_IDLE;
						end else if (pc_q == "(" && c == ":") begin
							ph_d  = PH_COMMENT;
							col_d = 1'b0;
						end else if (pc_q == "." && is_digit(c)) begin
							ph_d = PH_NUMBER;
						end else if (pc_q == "!") begin
							tok_v = 1'b1;
							tok   = mk(K_END, ts_q, '0, ERR_BAD_CHAR);
							ph_d  = PH_ERROR;
						end else begin
							tok_v    = 1'b1;
							tok      = mk(single_kind(pc_q), ts_q, POS_W'(1), ERR_NONE);
							do_start = 1'b1;
						end
					end
					default: begin
						do_start = 1'b1;
					end
				endcase

				if (do_start) begin
					ph_d  = st_ph;
					sec_v = st_emit;
					sec   = st_res;
					if (!st_space) begin
						ts_d = bp_q;
					end
					if (st_ph == PH_OPCHAR) begin
						pc_d = c;
					end
					if (st_ph == PH_STRING) begin
						qc_d = c;
						qs_d = 1'b0;
					end
					if (st_ph == PH_NAME) begin
						kb_d = 32'(c);
					end
				end
			end
		end

		bundle.cnt = {1'b0, tok_v} + {1'b0, sec_v};
		bundle.r0  = tok_v ? tok : sec;
		bundle.r1  = sec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			pc_q  <= '0;
			qc_q  <= '0;
			qs_q  <= 1'b0;
			col_q <= 1'b0;
			ts_q  <= '0;
			bp_q  <= '0;
			kb_q  <= '0;
		end else if (take) begin
			ph_q  <= ph_d;
			pc_q  <= pc_d;
			qc_q  <= qc_d;
			qs_q  <= qs_d;
			col_q <= col_d;
			ts_q  <= ts_d;
			bp_q  <= bp_d;
			kb_q  <= kb_d;
		end
	end

endmodule

// ===== rtl/xel_rq.sv =====
`timescale 1ns / 1ps
`include "xpath_expression_lexer_top_defines.svh"

module xel_rq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  xel_pkg::bundle_t bundle,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output xel_pkg::res_t    head_res,
	output logic             head_last
);
	import xel_pkg::*;

	bundle_t    bundles_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       wr_q;
	logic       sub_q;
	bundle_t    head;
	logic       out_fire;
	logic       pop;

	assign head      = bundles_q[rd_q];
	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign head_res  = sub_q ? head.r1 : head.r0;
	assign head_last = sub_q || (head.cnt == 2'd1);
	assign out_fire  = out_valid && out_ready;
	assign pop       = out_fire && head_last;

	always_ff @(posedge clk) begin
		if (push) begin
			bundles_q[wr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			sub_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q  <= ~rd_q;
				sub_q <= 1'b0;
			end else if (out_fire) begin
				sub_q <= 1'b1;
			end
		end
	end

	`XEL_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q != 2'd3)
	`XEL_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, cnt_q != 2'd2)
	`XEL_ASSERT_IMPL(a_head_nonempty, clk, arst_n, cnt_q != 2'd0, head.cnt != 2'd0)
	`XEL_ASSERT_IMPL(a_second_of_pair, clk, arst_n, sub_q, out_valid && head.cnt == 2'd2)

endmodule

// ===== rtl/xpath_expression_lexer_top.sv =====
`timescale 1ns / 1ps
// Results of a request enter the result queue on acceptance and are offered after earlier ones.
// Throughput: one request per cycle while the two-request queue has a free slot; results
// go out one per cycle while out_ready is high, both results of a request before the next one's.
// Requests that yield no result (bytes inside a token, whitespace) pass straight through.
// Reset: arst_n low clears the lexer to idle at offset zero and empties the result queue.

module xpath_expression_lexer_top #(
	parameter int MAX_SOURCE_BYTES = xel_pkg::DEF_MAX_SOURCE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  source_byte,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [15:0] token_length,
	output logic [2:0]  error_code,
	output logic        last_of_run
);
	import xel_pkg::*;

	logic    in_fire;
	logic    q_full;
	bundle_t bundle;
	res_t    head_res;

	// A request is taken whenever the queue has a free slot, even while the
	// downstream side is stalled on an earlier result.
	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;

	// The lexer state advances on every accepted request; its results are
	// formed in the same cycle and written into the queue as one bundle.
	xel_core #(
		.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (in_fire),
		.source_byte   (source_byte),
		.end_of_source (end_of_source),
		.bundle        (bundle)
	);

	// Bundles with no results are never stored, so the queue only ever holds
	// work for the output side.
	xel_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire && (bundle.cnt != 2'd0)),
		.bundle    (bundle),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head_res  (head_res),
		.head_last (last_of_run)
	);

	assign token_kind   = head_res.kind;
	assign start_offset = head_res.offset;
	assign token_length = head_res.length;
	assign error_code   = head_res.err;

endmodule
